[rtl/core/frt_pkg.sv]
`default_nettype none
package frt_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      FUNC_INSTALL    = 2'd0,
      FUNC_ACK        = 2'd1,
      FUNC_QUERY      = 2'd2,
      FUNC_REVALIDATE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NULL      = 3'd1,
      ST_OLD_GEN   = 3'd2,
      ST_OLD_EPOCH = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_MISMATCH  = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      RS_EMPTY      = 3'd0,
      RS_PENDING    = 3'd1,
      RS_INSTALLED  = 3'd2,
      RS_ACKED      = 3'd3,
      RS_REVALIDATE = 3'd4
   } route_state_type;

   typedef enum logic [1:0] {
      SEQ_IDLE   = 2'd0,
      SEQ_SCAN   = 2'd1,
      SEQ_DECIDE = 2'd2,
      SEQ_RESP   = 2'd3
   } seq_state_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] generation;
      logic [31:0] epoch;
      logic [31:0] boot_id;
      logic [2:0]  state;
   } route_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      route_type        data;
   } store_wr_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] route_generation;
      logic [31:0] route_epoch;
      logic [31:0] route_boot_id;
      logic [2:0]  route_state;
      logic [31:0] revalidated_total;
   } result_type;

endpackage
`default_nettype wire

[rtl/core/frt_if.sv]
`default_nettype none
interface frt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] slot_key;
   logic        null_service;
   logic [31:0] generation;
   logic [31:0] epoch;
   logic [31:0] boot_id;
   logic [2:0]  entry_state;

   modport source (output valid, func, slot_key, null_service, generation, epoch, boot_id,
                   entry_state, input ready);
   modport sink (input valid, func, slot_key, null_service, generation, epoch, boot_id,
                 entry_state, output ready);
endinterface

interface frt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] route_generation;
   logic [31:0] route_epoch;
   logic [31:0] route_boot_id;
   logic [2:0]  route_state;
   logic [31:0] revalidated_total;

   modport source (output valid, status, route_generation, route_epoch, route_boot_id,
                   route_state, revalidated_total, input ready);
   modport sink (input valid, status, route_generation, route_epoch, route_boot_id,
                 route_state, revalidated_total, output ready);
endinterface
`default_nettype wire

[rtl/core/frt_store.sv]
`default_nettype none
module frt_store (
   input  wire                        clock,
   input  frt_pkg::store_wr_type      wr,
   input  wire [frt_pkg::IDX_W-1:0]   rd_addr,
   output frt_pkg::route_type         rd_data
);

   frt_pkg::route_type mem [frt_pkg::ENTRIES];
   frt_pkg::route_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/frt_ctrl.sv]
`default_nettype none
module frt_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   frt_req_if.sink                    req_chan,
   output logic [frt_pkg::IDX_W-1:0]  rd_addr,
   input  frt_pkg::route_type         rd_data,
   output frt_pkg::store_wr_type      wr,
   output logic                       res_valid,
   output frt_pkg::result_type        res,
   input  wire                        res_take
);

   frt_pkg::seq_state_type     state_ff, state_in;
   logic [frt_pkg::CNT_W-1:0]  used_ff, used_in;
   logic [31:0]                cnt_ff, cnt_in;
   logic [frt_pkg::CNT_W-1:0]  issue_ff, issue_in;
   logic                       pend_ff, pend_in;
   logic                       found_ff, found_in;

   frt_pkg::func_type          func_ff, func_in;
   logic [31:0]                key_ff, key_in;
   logic [31:0]                gen_ff, gen_in;
   logic [31:0]                ep_ff, ep_in;
   logic [31:0]                boot_ff, boot_in;
   logic [2:0]                 st_ff, st_in;
   logic [frt_pkg::IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [frt_pkg::IDX_W-1:0]  hit_ff, hit_in;
   frt_pkg::route_type         rec_ff, rec_in;
   frt_pkg::result_type        res_ff, res_in;

   logic key_hit;
   logic live;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frt_pkg::SEQ_IDLE;
         used_ff  <= '0;
         cnt_ff   <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         cnt_ff   <= cnt_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      gen_ff      <= gen_in;
      ep_ff       <= ep_in;
      boot_ff     <= boot_in;
      st_ff       <= st_in;
      pend_idx_ff <= pend_idx_in;
      hit_ff      <= hit_in;
      rec_ff      <= rec_in;
      res_ff      <= res_in;
   end

   // shared key compare, one stored entry per cycle
   assign key_hit = pend_ff && (func_ff != frt_pkg::FUNC_REVALIDATE) && (rd_data.key == key_ff);
   assign live    = (rd_data.state == frt_pkg::RS_PENDING) ||
                    (rd_data.state == frt_pkg::RS_INSTALLED) ||
                    (rd_data.state == frt_pkg::RS_ACKED);

   assign req_chan.ready = (state_ff == frt_pkg::SEQ_IDLE);
   assign rd_addr        = issue_ff[frt_pkg::IDX_W-1:0];
   assign res_valid      = (state_ff == frt_pkg::SEQ_RESP);
   assign res            = res_ff;

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      cnt_in      = cnt_ff;
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      found_in    = found_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      gen_in      = gen_ff;
      ep_in       = ep_ff;
      boot_in     = boot_ff;
      st_in       = st_ff;
      pend_idx_in = pend_idx_ff;
      hit_in      = hit_ff;
      rec_in      = rec_ff;
      res_in      = res_ff;
      wr          = '0;

      unique case (state_ff)
         frt_pkg::SEQ_IDLE: begin
            if (req_chan.valid) begin
               func_in  = frt_pkg::func_type'(req_chan.func);
               key_in   = req_chan.slot_key;
               gen_in   = req_chan.generation;
               ep_in    = req_chan.epoch;
               boot_in  = req_chan.boot_id;
               st_in    = req_chan.entry_state;
               issue_in = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               if ((frt_pkg::func_type'(req_chan.func) == frt_pkg::FUNC_INSTALL) &&
                   req_chan.null_service) begin
                  res_in                   = '0;
                  res_in.status            = frt_pkg::ST_NULL;
                  res_in.revalidated_total = cnt_ff;
                  state_in                 = frt_pkg::SEQ_RESP;
               end else begin
                  state_in = frt_pkg::SEQ_SCAN;
               end
            end
         end

         frt_pkg::SEQ_SCAN: begin
            if (pend_ff && (func_ff == frt_pkg::FUNC_REVALIDATE) && live) begin
               wr.en         = 1'b1;
               wr.addr       = pend_idx_ff;
               wr.data       = rd_data;
               wr.data.state = frt_pkg::RS_REVALIDATE;
               cnt_in        = cnt_ff + 32'd1;
            end
            if (key_hit) begin
               found_in = 1'b1;
               hit_in   = pend_idx_ff;
               rec_in   = rd_data;
               pend_in  = 1'b0;
               state_in = frt_pkg::SEQ_DECIDE;
            end else if (issue_ff < used_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[frt_pkg::IDX_W-1:0];
               issue_in    = issue_ff + frt_pkg::CNT_W'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = frt_pkg::SEQ_DECIDE;
            end
         end

         frt_pkg::SEQ_DECIDE: begin
            res_in                   = '0;
            res_in.revalidated_total = cnt_ff;
            state_in                 = frt_pkg::SEQ_RESP;
            unique case (func_ff)
               frt_pkg::FUNC_INSTALL: begin
                  if (found_ff) begin
                     if (gen_ff <= rec_ff.generation) begin
                        res_in.status = frt_pkg::ST_OLD_GEN;
                     end else if (ep_ff < rec_ff.epoch) begin
                        res_in.status = frt_pkg::ST_OLD_EPOCH;
                     end else begin
                        wr.en   = 1'b1;
                        wr.addr = hit_ff;
                        wr.data = '{key: key_ff, generation: gen_ff, epoch: ep_ff,
                                    boot_id: boot_ff, state: st_ff};
                     end
                  end else if (used_ff == frt_pkg::CNT_W'(frt_pkg::ENTRIES)) begin
                     res_in.status = frt_pkg::ST_FULL;
                  end else begin
                     wr.en   = 1'b1;
                     wr.addr = used_ff[frt_pkg::IDX_W-1:0];
                     wr.data = '{key: key_ff, generation: gen_ff, epoch: ep_ff,
                                 boot_id: boot_ff, state: st_ff};
                     used_in = used_ff + frt_pkg::CNT_W'(1);
                  end
               end
               frt_pkg::FUNC_ACK: begin
                  if (!found_ff) begin
                     res_in.status = frt_pkg::ST_NOT_FOUND;
                  end else if ((rec_ff.generation != gen_ff) || (rec_ff.boot_id != boot_ff) ||
                               ((rec_ff.state != frt_pkg::RS_INSTALLED) &&
                                (rec_ff.state != frt_pkg::RS_PENDING))) begin
                     res_in.status = frt_pkg::ST_MISMATCH;
                  end else begin
                     wr.en         = 1'b1;
                     wr.addr       = hit_ff;
                     wr.data       = rec_ff;
                     wr.data.state = frt_pkg::RS_ACKED;
                  end
               end
               frt_pkg::FUNC_QUERY: begin
                  if (!found_ff || (rec_ff.state == frt_pkg::RS_EMPTY)) begin
                     res_in.status = frt_pkg::ST_NOT_FOUND;
                  end else begin
                     res_in.route_generation = rec_ff.generation;
                     res_in.route_epoch      = rec_ff.epoch;
                     res_in.route_boot_id    = rec_ff.boot_id;
                     res_in.route_state      = rec_ff.state;
                  end
               end
               frt_pkg::FUNC_REVALIDATE: begin
                  res_in.status = frt_pkg::ST_OK;
               end
            endcase
         end

         frt_pkg::SEQ_RESP: begin
            if (res_take) begin
               state_in = frt_pkg::SEQ_IDLE;
            end
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= frt_pkg::CNT_W'(frt_pkg::ENTRIES))
      else $error("route count exceeds table size");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) |-> (used_ff == $past(used_ff) + frt_pkg::CNT_W'(1)))
      else $error("route count moved by more than one");

   a_cnt_reval: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |->
         ($past(state_ff) == frt_pkg::SEQ_SCAN && $past(func_ff) == frt_pkg::FUNC_REVALIDATE))
      else $error("revalidate count changed outside a revalidate scan");

   a_wr_busy: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == frt_pkg::SEQ_SCAN || state_ff == frt_pkg::SEQ_DECIDE))
      else $error("table write while not processing a transaction");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == frt_pkg::SEQ_SCAN) |-> (issue_ff <= used_ff))
      else $error("scan ran past the routes in use");
`endif

endmodule
`default_nettype wire

[rtl/core/fenced_route_table.sv]
// Fenced route table: up to ENTRIES routes keyed by a 32-bit slot key.
// req_chan carries one command transaction (install, acknowledge, query,
// revalidate all); rsp_chan returns exactly one result transaction per
// command, in order. Both channels use valid/ready.
// Each command walks the routes in use through the single read port of the
// route memory, one entry per cycle, with one shared key comparator, then
// passes through the decide and result states before its result sits in the
// output register (a hit stops the walk early); revalidate all always walks
// every route. An install with a null service skips the walk and goes
// straight to the result state. req_chan.ready is high only while no
// command is in progress, so at most one command is in flight and a new
// command is accepted only once the last one has left the result state.
// Reset (synchronous, active high) empties the table and zeroes the
// revalidate count; the route memory itself is not cleared.
// If rsp_chan stalls, the result holds in the output register; the next
// command is still accepted and processed, and then waits for that
// register to drain before presenting its own result.
`default_nettype none
module fenced_route_table (
   input  wire         clock,
   input  wire         reset,
   frt_req_if.sink     req_chan,
   frt_rsp_if.source   rsp_chan
);

   logic [frt_pkg::IDX_W-1:0] rd_addr;
   frt_pkg::route_type        rd_data;
   frt_pkg::store_wr_type     wr;
   logic                      res_valid;
   frt_pkg::result_type       res;
   logic                      res_take;

   logic                      valid_ff, valid_in;
   frt_pkg::result_type       out_ff, out_in;

   frt_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   frt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr        (wr),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   assign res_take = res_valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      valid_in = valid_ff && !rsp_chan.ready;
      out_in   = out_ff;
      if (res_take) begin
         valid_in = 1'b1;
         out_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid             = valid_ff;
   assign rsp_chan.status            = out_ff.status;
   assign rsp_chan.route_generation  = out_ff.route_generation;
   assign rsp_chan.route_epoch       = out_ff.route_epoch;
   assign rsp_chan.route_boot_id     = out_ff.route_boot_id;
   assign rsp_chan.route_state       = out_ff.route_state;
   assign rsp_chan.revalidated_total = out_ff.revalidated_total;

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_ITEMS = 630;
   localparam int PHASE_LEN    = 218;
   localparam int KEY_POOL     = 72;
   localparam int STALL_AT     = 520;
   localparam int STALL_CYCLES = 300;
   localparam int DRAIN_CYCLES = 150;

   typedef struct {
      frt_pkg::func_type func;
      logic [31:0]       slot_key;
      logic              null_service;
      logic [31:0]       generation;
      logic [31:0]       epoch;
      logic [31:0]       boot_id;
      logic [2:0]        entry_state;
   } route_cmd_type;

   logic clock = 1'b0;
   logic reset;

   frt_req_if req_bus ();
   frt_rsp_if rsp_bus ();

   fenced_route_table uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   // shadow route table
   logic [31:0] tbl_key   [frt_pkg::ENTRIES];
   logic [31:0] tbl_gen   [frt_pkg::ENTRIES];
   logic [31:0] tbl_epoch [frt_pkg::ENTRIES];
   logic [31:0] tbl_boot  [frt_pkg::ENTRIES];
   logic [2:0]  tbl_state [frt_pkg::ENTRIES];
   int          tbl_used = 0;
   logic [31:0] revalidate_total = '0;

   route_cmd_type       cmd_queue [$];
   frt_pkg::result_type route_expect_q [$];
   route_cmd_type       next_cmd;

   int accept_count   = 0;
   int issued_count   = 0;
   int mismatch_count = 0;
   int tx_idle_pct    = 35;
   int rx_idle_pct    = 49;
   bit stall_hold     = 1'b0;

   function automatic int find_route(input logic [31:0] key);
      for (int i = 0; i < tbl_used; i++)
         if (tbl_key[i] == key) return i;
      return -1;
   endfunction

   function automatic frt_pkg::result_type route_table_predict(input route_cmd_type c);
      frt_pkg::result_type r;
      int idx;
      r = '0;
      r.status = frt_pkg::ST_OK;
      idx = find_route(c.slot_key);
      case (c.func)
         frt_pkg::FUNC_INSTALL: begin
            if (c.null_service) r.status = frt_pkg::ST_NULL;
            else if (idx >= 0) begin
               if (c.generation <= tbl_gen[idx]) r.status = frt_pkg::ST_OLD_GEN;
               else if (c.epoch < tbl_epoch[idx]) r.status = frt_pkg::ST_OLD_EPOCH;
               else begin
                  tbl_gen[idx]   = c.generation;
                  tbl_epoch[idx] = c.epoch;
                  tbl_boot[idx]  = c.boot_id;
                  tbl_state[idx] = c.entry_state;
               end
            end else if (tbl_used >= frt_pkg::ENTRIES) r.status = frt_pkg::ST_FULL;
            else begin
               tbl_key[tbl_used]   = c.slot_key;
               tbl_gen[tbl_used]   = c.generation;
               tbl_epoch[tbl_used] = c.epoch;
               tbl_boot[tbl_used]  = c.boot_id;
               tbl_state[tbl_used] = c.entry_state;
               tbl_used++;
            end
         end
         frt_pkg::FUNC_ACK: begin
            if (idx < 0) r.status = frt_pkg::ST_NOT_FOUND;
            else if (tbl_gen[idx] != c.generation || tbl_boot[idx] != c.boot_id ||
                     (tbl_state[idx] != frt_pkg::RS_INSTALLED &&
                      tbl_state[idx] != frt_pkg::RS_PENDING))
               r.status = frt_pkg::ST_MISMATCH;
            else tbl_state[idx] = frt_pkg::RS_ACKED;
         end
         frt_pkg::FUNC_QUERY: begin
            if (idx < 0 || tbl_state[idx] == frt_pkg::RS_EMPTY)
               r.status = frt_pkg::ST_NOT_FOUND;
            else begin
               r.route_generation = tbl_gen[idx];
               r.route_epoch      = tbl_epoch[idx];
               r.route_boot_id    = tbl_boot[idx];
               r.route_state      = tbl_state[idx];
            end
         end
         default: begin
            for (int i = 0; i < tbl_used; i++)
               if (tbl_state[i] == frt_pkg::RS_ACKED || tbl_state[i] == frt_pkg::RS_INSTALLED ||
                   tbl_state[i] == frt_pkg::RS_PENDING) begin
                  tbl_state[i] = frt_pkg::RS_REVALIDATE;
                  revalidate_total++;
               end
         end
      endcase
      r.revalidated_total = revalidate_total;
      return r;
   endfunction

   task automatic add_cmd(input frt_pkg::func_type f, input logic [31:0] key,
                          input logic nul, input logic [31:0] gen, input logic [31:0] ep,
                          input logic [31:0] boot, input logic [2:0] st);
      route_cmd_type c;
      c.func = f;
      c.slot_key = key;
      c.null_service = nul;
      c.generation = gen;
      c.epoch = ep;
      c.boot_id = boot;
      c.entry_state = st;
      cmd_queue = {cmd_queue, c};
   endtask

   task automatic check_field(input string name, input logic [31:0] exp,
                              input logic [31:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
         mismatch_count++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (accept_count == issued_count) begin
         if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            next_cmd = cmd_queue.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.func         <= next_cmd.func;
            req_bus.slot_key     <= next_cmd.slot_key;
            req_bus.null_service <= next_cmd.null_service;
            req_bus.generation   <= next_cmd.generation;
            req_bus.epoch        <= next_cmd.epoch;
            req_bus.boot_id      <= next_cmd.boot_id;
            req_bus.entry_state  <= next_cmd.entry_state;
            issued_count++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !stall_hold && ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      route_cmd_type c;
      frt_pkg::result_type exp;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            c.func = frt_pkg::func_type'(req_bus.func);
            c.slot_key = req_bus.slot_key;
            c.null_service = req_bus.null_service;
            c.generation = req_bus.generation;
            c.epoch = req_bus.epoch;
            c.boot_id = req_bus.boot_id;
            c.entry_state = req_bus.entry_state;
            route_expect_q = {route_expect_q, route_table_predict(c)};
            accept_count++;
            if (accept_count < PHASE_LEN) begin
               tx_idle_pct = 35;
               rx_idle_pct = 49;
            end else if (accept_count < 2 * PHASE_LEN) begin
               tx_idle_pct = 49;
               rx_idle_pct = 35;
            end else begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (route_expect_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none actual status %h",
                        $time, rsp_bus.status);
               mismatch_count++;
            end else begin
               exp = route_expect_q.pop_front();
               check_field("status", 32'(exp.status), 32'(rsp_bus.status));
               check_field("route_generation", exp.route_generation,
                           rsp_bus.route_generation);
               check_field("route_epoch", exp.route_epoch, rsp_bus.route_epoch);
               check_field("route_boot_id", exp.route_boot_id, rsp_bus.route_boot_id);
               check_field("route_state", 32'(exp.route_state), 32'(rsp_bus.route_state));
               check_field("revalidated_total", exp.revalidated_total,
                           rsp_bus.revalidated_total);
            end
         end
      end
   end

   // long receiver hold-off while requests keep coming
   initial begin
      wait (accept_count >= STALL_AT);
      @(posedge clock);
      stall_hold = 1'b1;
      repeat (STALL_CYCLES) @(posedge clock);
      stall_hold = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      logic [31:0] pool_key   [KEY_POOL];
      logic [31:0] pool_gen   [KEY_POOL];
      logic [31:0] pool_epoch [KEY_POOL];
      logic [31:0] pool_boot  [KEY_POOL];
      int k, r, op;
      logic [31:0] key;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = frt_pkg::FUNC_INSTALL;
      req_bus.slot_key = '0;
      req_bus.null_service = 1'b0;
      req_bus.generation = '0;
      req_bus.epoch = '0;
      req_bus.boot_id = '0;
      req_bus.entry_state = frt_pkg::RS_EMPTY;
      rsp_bus.ready = 1'b0;

      // directed: empty table, null service, stale generation and epoch,
      // ack failures, empty and out-of-range states, revalidate
      add_cmd(frt_pkg::FUNC_QUERY, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0, frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_ACK, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0, frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_REVALIDATE, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
              frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_INSTALL, 32'h0, 1'b1, 32'h5, 32'h5, 32'hffff_ffff,
              frt_pkg::RS_PENDING);
      add_cmd(frt_pkg::FUNC_INSTALL, 32'h0, 1'b0, 32'h5, 32'h5, 32'hffff_ffff,
              frt_pkg::RS_PENDING);
      add_cmd(frt_pkg::FUNC_INSTALL, 32'h0, 1'b0, 32'h5, 32'h9, 32'h1,
              frt_pkg::RS_INSTALLED);
      add_cmd(frt_pkg::FUNC_INSTALL, 32'h0, 1'b0, 32'h4, 32'h9, 32'h1,
              frt_pkg::RS_INSTALLED);
      add_cmd(frt_pkg::FUNC_INSTALL, 32'h0, 1'b0, 32'h6, 32'h4, 32'h1,
              frt_pkg::RS_INSTALLED);
      add_cmd(frt_pkg::FUNC_ACK, 32'h0, 1'b0, 32'h5, 32'h0, 32'hffff_fffe,
              frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_ACK, 32'h0, 1'b0, 32'h4, 32'h0, 32'hffff_ffff,
              frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_ACK, 32'h0, 1'b0, 32'h5, 32'h0, 32'hffff_ffff,
              frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_ACK, 32'h0, 1'b0, 32'h5, 32'h0, 32'hffff_ffff,
              frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_QUERY, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0, frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_INSTALL, 32'hffff_ffff, 1'b0, 32'hffff_ffff, 32'hffff_ffff,
              32'h0, frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_QUERY, 32'hffff_ffff, 1'b0, 32'h0, 32'h0, 32'h0,
              frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_INSTALL, 32'h1, 1'b0, 32'h1, 32'h0, 32'h1234_5678, 3'd7);
      add_cmd(frt_pkg::FUNC_QUERY, 32'h1, 1'b0, 32'h0, 32'h0, 32'h0, frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_ACK, 32'h1, 1'b0, 32'h1, 32'h0, 32'h1234_5678,
              frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_INSTALL, 32'h2, 1'b0, 32'h0, 32'h0, 32'h0,
              frt_pkg::RS_INSTALLED);
      add_cmd(frt_pkg::FUNC_REVALIDATE, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 3'd7);
      add_cmd(frt_pkg::FUNC_QUERY, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0, frt_pkg::RS_EMPTY);
      add_cmd(frt_pkg::FUNC_INSTALL, 32'h0, 1'b0, 32'h6, 32'h5, 32'h0,
              frt_pkg::RS_INSTALLED);
      add_cmd(frt_pkg::FUNC_INSTALL, 32'h0, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'h0,
              frt_pkg::RS_ACKED);
      add_cmd(frt_pkg::FUNC_REVALIDATE, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
              frt_pkg::RS_EMPTY);

      for (int i = 0; i < KEY_POOL; i++) begin
         pool_key[i]   = $urandom;
         pool_gen[i]   = '0;
         pool_epoch[i] = '0;
         pool_boot[i]  = '0;
      end

      // mostly well-formed install/ack sequences over a key pool larger than
      // the table, so the table fills; the rest is noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         k = $urandom_range(0, KEY_POOL - 1);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            op = $urandom_range(0, 99);
            if (op < 45) begin
               pool_gen[k]   = pool_gen[k] + $urandom_range(1, 3);
               pool_epoch[k] = pool_epoch[k] + $urandom_range(0, 1);
               pool_boot[k]  = $urandom;
               add_cmd(frt_pkg::FUNC_INSTALL, pool_key[k], ($urandom_range(0, 19) == 0),
                       pool_gen[k], pool_epoch[k], pool_boot[k],
                       ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 4))
                                                   : 3'($urandom_range(1, 2)));
            end else if (op < 80) begin
               add_cmd(frt_pkg::FUNC_ACK, pool_key[k], 1'b0, pool_gen[k], $urandom,
                       pool_boot[k], frt_pkg::RS_EMPTY);
            end else if (op < 95) begin
               add_cmd(frt_pkg::FUNC_QUERY, pool_key[k], 1'b0, $urandom, $urandom, $urandom,
                       frt_pkg::RS_EMPTY);
            end else begin
               add_cmd(frt_pkg::FUNC_REVALIDATE, pool_key[k], 1'b0, 32'h0, 32'h0, 32'h0,
                       frt_pkg::RS_EMPTY);
            end
         end else begin
            key = ($urandom_range(0, 1) == 0) ? pool_key[k] : $urandom;
            add_cmd(frt_pkg::func_type'($urandom_range(0, 3)), key,
                    1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                    3'($urandom_range(0, 7)));
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() > 0 || accept_count != issued_count ||
             route_expect_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
